FILE: rtl/hdf_pkg.sv
// Shared types, constants and the CRC byte update for the HDLC deframer.
package hdf_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int BYTE_CNT_W      = $clog2(MAX_FRAME_BYTES);
    localparam int FRAME_LEN_W     = 11;
    localparam int EVENT_W         = 3;

    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam logic [2:0] FLAG_RUN  = 3'd6;
    localparam logic [2:0] ABORT_RUN = 3'd7;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    localparam logic [7:0] MIN_LENGTH_RESET = 8'd10;

    localparam logic [EVENT_W-1:0] EV_OCTET  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_GOOD   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_BADCRC = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SHORT  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ABORT  = 3'd4;

    typedef struct packed {
        logic [EVENT_W-1:0]     event_res;
        logic [7:0]             octet;
        logic [FRAME_LEN_W-1:0] frame_length;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/hdlc_deframer_fcs_check.sv
// Top level of the HDLC deframer with CRC-16/X.25 frame check.
// One received line bit is taken per word, and a new bit can be taken in every cycle
// while the output is not stalled; each bit passes from the input register through one
// step of the deframer state to the result register, which presents its result word.
// A stalled output holds back the input. A bit yields at most one result word: an
// octet, or a frame verdict (good, bad CRC, too short) at a closing flag, or an abort
// after seven ones. Stuffed zeros and empty frames give no word. The minimum length
// register resets to 10 and should be written only while idle.
module hdlc_deframer_fcs_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] line_bit, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] octet, [18:8] frame_length, [23:19] zero
    output logic [2:0]  m_axis_tuser    // [2:0] event_res
);
    import hdf_pkg::*;

    logic    in_valid;
    logic    in_bit;
    logic    can_load;
    logic    take;
    logic    res_valid;
    t_result res;

    assign take = in_valid && can_load;

    hdf_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_take        (take),
        .o_valid       (in_valid),
        .o_bit         (in_bit)
    );

    hdf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_bit       (in_bit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hdf_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (res_valid),
        .i_res         (res),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule

FILE: rtl/hdf_in_reg.sv
// Input register that holds one received line bit for the deframer core.
module hdf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [0] line_bit, [7:1] zero
    input  logic       i_take,
    output logic       o_valid,
    output logic       o_bit
);
    logic r_valid;
    logic r_bit;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_bit         = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_bit <= s_axis_tdata[0];
        end
    end
endmodule

FILE: rtl/hdf_core.sv
// Deframer state and one-bit step: destuffing, flag and abort detection, CRC check.
module hdf_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_take,
    input  logic            i_bit,
    output logic            o_res_valid,
    output hdf_pkg::t_result o_res
);
    import hdf_pkg::*;

    logic [2:0]            r_ones_run,    n_ones_run;
    logic [2:0]            r_bit_count,   n_bit_count;
    logic [7:0]            r_octet_shift, n_octet_shift;
    logic [BYTE_CNT_W-1:0] r_byte_count,  n_byte_count;
    logic [15:0]           r_crc,         n_crc;
    logic [15:0]           r_held,        n_held;
    logic [7:0]            r_min_length;

    logic [2:0]            v_ones;
    logic [2:0]            v_bits;
    logic [7:0]            v_shift;
    logic [BYTE_CNT_W-1:0] v_cnt;
    logic [15:0]           v_crc;
    logic [15:0]           v_held;
    logic [7:0]            v_new_shift;
    logic [BYTE_CNT_W:0]   v_cnt_inc;

    always_comb begin
        n_ones_run    = r_ones_run;
        n_bit_count   = r_bit_count;
        n_octet_shift = r_octet_shift;
        n_byte_count  = r_byte_count;
        n_crc         = r_crc;
        n_held        = r_held;
        o_res_valid   = 1'b0;
        o_res         = '0;
        v_ones        = i_bit ? (r_ones_run + 3'd1) : r_ones_run;
        v_bits        = r_bit_count;
        v_shift       = r_octet_shift;
        v_cnt         = r_byte_count;
        v_crc         = r_crc;
        v_held        = r_held;
        v_new_shift   = {i_bit, r_octet_shift[7:1]};
        v_cnt_inc     = '0;

        if (i_take) begin
            if (!i_bit && v_ones == STUFF_RUN) begin
                n_ones_run = 3'd0;
            end else if (!i_bit && v_ones == FLAG_RUN) begin
                if (r_byte_count != '0) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_length = FRAME_LEN_W'(r_byte_count);
                    if (r_byte_count > BYTE_CNT_W'(r_min_length) &&
                        r_byte_count >= BYTE_CNT_W'(2)) begin
                        o_res.event_res = ((r_crc ^ CRC_XOROUT) == r_held) ? EV_GOOD
                                                                            : EV_BADCRC;
                    end else begin
                        o_res.event_res = EV_SHORT;
                    end
                end
                n_bit_count  = 3'd0;
                n_ones_run   = 3'd0;
                n_byte_count = '0;
                n_crc        = CRC_INIT;
                n_held       = '0;
            end else begin
                if (v_ones == ABORT_RUN) begin
                    o_res_valid        = 1'b1;
                    o_res.event_res    = EV_ABORT;
                    o_res.frame_length = FRAME_LEN_W'(r_byte_count);
                    v_ones  = 3'd0;
                    v_bits  = 3'd0;
                    v_shift = 8'h00;
                    v_cnt   = '0;
                    v_crc   = CRC_INIT;
                    v_held  = '0;
                end
                v_new_shift   = {i_bit, v_shift[7:1]};
                n_ones_run    = i_bit ? v_ones : 3'd0;
                n_octet_shift = v_new_shift;
                n_bit_count   = v_bits + 3'd1;
                n_byte_count  = v_cnt;
                n_crc         = v_crc;
                n_held        = v_held;
                if (v_bits == LAST_BIT) begin
                    if (v_cnt >= BYTE_CNT_W'(2)) begin
                        n_crc = crc_byte(v_crc, v_held[7:0]);
                    end
                    n_held             = {v_new_shift, v_held[15:8]};
                    v_cnt_inc          = {1'b0, v_cnt} + (BYTE_CNT_W + 1)'(1);
                    o_res_valid        = 1'b1;
                    o_res.event_res    = EV_OCTET;
                    o_res.octet        = v_new_shift;
                    o_res.frame_length = FRAME_LEN_W'(v_cnt_inc);
                    if (v_cnt_inc >= (BYTE_CNT_W + 1)'(MAX_FRAME_BYTES)) begin
                        n_byte_count = '0;
                        n_crc        = CRC_INIT;
                        n_held       = '0;
                    end else begin
                        n_byte_count = v_cnt_inc[BYTE_CNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ones_run    <= 3'd0;
            r_bit_count   <= 3'd0;
            r_octet_shift <= 8'h00;
            r_byte_count  <= '0;
            r_crc         <= CRC_INIT;
            r_held        <= '0;
            r_min_length  <= MIN_LENGTH_RESET;
        end else begin
            r_ones_run    <= n_ones_run;
            r_bit_count   <= n_bit_count;
            r_octet_shift <= n_octet_shift;
            r_byte_count  <= n_byte_count;
            r_crc         <= n_crc;
            r_held        <= n_held;
            if (i_cfg_we) begin
                r_min_length <= i_cfg_wdata;
            end
        end
    end

    a_run_below_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones_run != ABORT_RUN)
        else $error("ones run counter holds the abort count");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.event_res != EV_OCTET) |=>
        (r_crc == CRC_INIT && r_held == '0 && r_byte_count == '0))
        else $error("frame state not cleared after a frame end");

    a_octet_on_byte_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.event_res == EV_OCTET && o_res.frame_length != '0) |=>
        (r_bit_count == 3'd0 && r_held[15:8] == $past(o_res.octet)))
        else $error("octet event not aligned with the held octets");

    a_result_needs_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |-> !o_res_valid)
        else $error("result produced without a bit taken");
endmodule

FILE: rtl/hdf_out_reg.sv
// Result register that drives the output stream of the deframer.
module hdf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hdf_pkg::t_result i_res,
    output logic             o_can_load,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [7:0] octet, [18:8] frame_length, [23:19] zero
    output logic [2:0]       m_axis_tuser   // [2:0] event_res
);
    import hdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load    = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'b00000, r_res.frame_length, r_res.octet};
    assign m_axis_tuser  = r_res.event_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end
endmodule
